@@ rtl/core/sieve_pkg.sv @@
// sieve_pkg: shared constants, types and helpers for the segmented sieve
// no dependencies
package sieve_pkg;
	localparam int unsigned SEGMENT_BITS_DEF = 65536;
	localparam int unsigned VAL_W = 40;
	localparam int unsigned PRIME_W = 20;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned BIT_IDX_W = 6;
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SQ, ST_CHK, ST_DIV, ST_START, ST_MARK, ST_CNT, ST_OUT
	} state_t;

	function automatic logic [6:0] popcnt64(input logic [WORD_W-1:0] w);
		logic [6:0] c;
		c = '0;
		for (int i = 0; i < WORD_W; i++) c = c + {6'd0, w[i]};
		return c;
	endfunction
endpackage

@@ rtl/core/sieve_div.sv @@
// sieve_div: radix-2 restoring divider, one quotient bit per cycle, gives the remainder
// depends on sieve_pkg
module sieve_div import sieve_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [VAL_W:0]       num,
	input  logic [PRIME_W-1:0]   den,
	output logic                 done,
	output logic [PRIME_W-1:0]   rem
);
	logic [VAL_W:0] q_q;
	logic [PRIME_W:0] r_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [PRIME_W+1:0] trial;

	assign trial = {r_q, q_q[VAL_W]};
	assign rem = r_q[PRIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(VAL_W + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			if (trial >= {2'b0, den}) begin
				r_q <= (PRIME_W+1)'(trial - {2'b0, den});
				q_q <= {q_q[VAL_W-1:0], 1'b1};
			end else begin
				r_q <= trial[PRIME_W:0];
				q_q <= {q_q[VAL_W-1:0], 1'b0};
			end
		end
	end
endmodule

@@ rtl/core/sieve_store.sv @@
// sieve_store: bit store memory, one word per address, registered read
// depends on sieve_pkg
module sieve_store import sieve_pkg::*; #(
	parameter int unsigned WORDS = SEGMENT_BITS_DEF / WORD_W,
	parameter int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);
	logic [WORD_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/segmented_prime_sieve_counter.sv @@
// segmented_prime_sieve_counter: top level, sequencer around the bit store
// Ports: start/busy command channel with base_prime and last_prime; a
// cfg_valid/cfg_ready write channel (index 0 segment_low, 1 segment_high);
// prime_count with strobe done, shown for one cycle, the receiver cannot stall.
// Sequence: after reset a clearing pass fills the store with ones, busy
// high throughout. Each prime first has a setup in which a bit-serial
// divider computes ceil(low/p), then one read-modify-write per marked
// multiple, a read and then a write of the same store word. A prime whose
// square exceeds the top passes only the square and check states. The last
// item adds a count scan of one word per cycle over the segment and then a
// refill pass that writes ones to every word; done pulses after the scan.
// Items are handled one at a time; busy is high while one is in work. cfg_ready is
// always high; the user must write registers only while busy is low (not enforced).
module segmented_prime_sieve_counter import sieve_pkg::*; #(
	parameter int unsigned SEGMENT_BITS = SEGMENT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [PRIME_W-1:0]   base_prime,
	input  logic                 last_prime,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output logic                 done,
	output logic [COUNT_W-1:0]   prime_count
);
	localparam int unsigned WORDS = (SEGMENT_BITS + WORD_W - 1) / WORD_W;
	localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned IW = $clog2(SEGMENT_BITS) + 1;

	state_t state_q, state_d;
	logic [VAL_W-1:0] low_q, high_q, top_q, sq_q;
	logic [VAL_W:0] j_q, first_q;
	logic [PRIME_W-1:0] p_q;
	logic last_q, exh_q, empty_q, phase_q;
	logic [AW:0] addr_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [IW-1:0] n_q;
	logic div_go, div_done;
	logic [PRIME_W-1:0] rem;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [WORD_W-1:0] wdata, rdata;
	logic [VAL_W-1:0] idx, rem_bits;
	logic [VAL_W:0] cap, num_w;
	logic [WORD_W-1:0] cmask;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign cap = {1'b0, low_q} + (VAL_W+1)'(SEGMENT_BITS - 1);
	assign idx = VAL_W'(j_q - {1'b0, low_q});
	assign num_w = {1'b0, low_q} + (VAL_W+1)'(p_q) - (VAL_W+1)'(1);

	sieve_div u_div (.clk, .arst_n, .go(div_go), .num(num_w),
		.den(p_q), .done(div_done), .rem);
	sieve_store #(.WORDS(WORDS), .AW(AW)) u_store (.clk, .we, .waddr, .wdata,
		.raddr, .rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			low_q <= 40'd2;
			high_q <= 40'd65537;
			exh_q <= 1'b0;
			addr_q <= '0;
			phase_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LOW: low_q <= cfg_data;
					REG_HIGH: high_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					phase_q <= 1'b0;
					cnt_q <= '0;
				end
				ST_CLEAR: begin
					addr_q <= addr_q + (AW+1)'(1);
					if (state_d == ST_IDLE) exh_q <= 1'b0;
				end
				ST_CHK: if (!empty_q && p_q != '0 && sq_q > top_q) exh_q <= 1'b1;
				ST_MARK: phase_q <= (state_d == ST_MARK) ? ~phase_q : 1'b0;
				ST_CNT: begin
					if (phase_q) begin
						if (n_q >= IW'(WORD_W)) cnt_q <= cnt_q + COUNT_W'(popcnt64(rdata));
						else cnt_q <= cnt_q + COUNT_W'(popcnt64(rdata & cmask));
					end
					if (phase_q || addr_q == '0) addr_q <= addr_q + (AW+1)'(1);
					phase_q <= 1'b1;
				end
				ST_OUT: addr_q <= '0;
				default: ;
			endcase
		end
	end

	assign rem_bits = VAL_W'(n_q);
	always_comb begin
		cmask = '0;
		for (int i = 0; i < WORD_W; i++) cmask[i] = (rem_bits > VAL_W'(i));
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				p_q <= base_prime;
				last_q <= last_prime;
				empty_q <= (high_q < low_q);
				top_q <= ({1'b0, high_q} < cap) ? high_q : VAL_W'(cap);
			end
			ST_SQ: sq_q <= VAL_W'(p_q) * VAL_W'(p_q);
			ST_START: j_q <= ({1'b0, sq_q} > first_q) ? {1'b0, sq_q} : first_q;
			ST_MARK: if (phase_q) j_q <= j_q + (VAL_W+1)'(p_q);
			ST_CNT: begin
				if (addr_q == '0 && !phase_q) n_q <= IW'(top_q - low_q + 40'd1);
				else if (phase_q) n_q <= (n_q > IW'(WORD_W)) ? n_q - IW'(WORD_W) : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) if (div_done) first_q <= num_w - (VAL_W+1)'(rem);

	always_comb begin
		state_d = state_q;
		div_go = 1'b0;
		we = 1'b0;
		waddr = addr_q[AW-1:0];
		wdata = '1;
		raddr = idx[BIT_IDX_W+AW-1:BIT_IDX_W];
		done = 1'b0;
		prime_count = cnt_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SQ;
			ST_CLEAR: begin
				we = 1'b1;
				if (addr_q == (AW+1)'(WORDS - 1)) state_d = ST_IDLE;
			end
			ST_SQ: state_d = ST_CHK;
			ST_CHK: begin
				if (exh_q || empty_q || p_q == '0 || sq_q > top_q) begin
					state_d = last_q ? ST_CNT : ST_IDLE;
				end else begin
					div_go = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: if (div_done) state_d = ST_START;
			ST_START: state_d = ST_MARK;
			ST_MARK: begin
				if (!phase_q) begin
					if (j_q > {1'b0, top_q}) state_d = last_q ? ST_CNT : ST_IDLE;
				end else begin
					we = 1'b1;
					waddr = idx[BIT_IDX_W+AW-1:BIT_IDX_W];
					wdata = rdata & ~(64'd1 << idx[BIT_IDX_W-1:0]);
				end
			end
			ST_CNT: begin
				raddr = addr_q[AW-1:0];
				if (empty_q) state_d = ST_OUT;
				else if (phase_q && (n_q <= IW'(WORD_W))) state_d = ST_OUT;
			end
			ST_OUT: begin
				done = 1'b1;
				if (empty_q) prime_count = '0;
				state_d = ST_CLEAR;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
